### rtl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int SLOTS_DEFAULT     = 1024;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;
   localparam int COUNT_RESET = 1024;

   localparam int DIV_SHIFT  = 20;
   localparam int DIV_PROD_W = 31;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_RD    = 7'b0010000,
      ST_FREE  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

### rtl/bsa_ram.sv
`timescale 1ns / 1ps

module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bitmap_slot_allocator_unit.sv
`timescale 1ns / 1ps

// Slot allocator over a used-bit bitmap kept in a RAM of ceil(SLOTS/WORD_BITS) words.
// An allocate scans the words from the lowest upward through one shared find-first-zero
// unit, one word per cycle behind the registered RAM read, and takes the lowest free slot
// of the first word that has one; if none has, it answers with the full status.
// A free splits the index by reciprocal multiply, then reads, clears and writes the word;
// an out-of-range free skips the RAM. One transaction is in flight at a time; a
// result waits in the output register while the next request is accepted.
// After reset and after every write of the slot count the RAM is swept clear,
// one word per cycle, and no request is accepted during that pass.
// Slots at or above the count read as used without being stored.

module bitmap_slot_allocator_unit #(
   parameter int SLOTS     = bsa_pkg::SLOTS_DEFAULT,
   parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,   // slot_count

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [9:0] slot_index
   input  logic [0:0]  req_tuser,     // [0] operation

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [9:0] slot_index_res
   output logic [1:0]  rsp_tuser      // [1:0] status
);

   localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int WCW    = $clog2(NWORDS + 1);
   localparam int SPAN_W = $clog2(NWORDS * WORD_BITS + 1);
   localparam int CW     = (SPAN_W > bsa_pkg::COUNT_W) ? SPAN_W : bsa_pkg::COUNT_W;
   localparam int BW     = $clog2(WORD_BITS);
   localparam int DIV_MULT = ((1 << bsa_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int COUNT_INIT =
      (bsa_pkg::COUNT_RESET > SLOTS) ? SLOTS : bsa_pkg::COUNT_RESET;
   localparam int PW = bsa_pkg::DIV_PROD_W;

   bsa_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [WCW-1:0]               word_ff, word_in;
   logic [AW-1:0]                chk_ff, chk_in;
   logic                         pend_ff, pend_in;
   logic [bsa_pkg::INDEX_W-1:0]  idx_ff, idx_in;
   logic [AW-1:0]                quot_ff, quot_in;
   logic [BW-1:0]                bit_ff, bit_in;
   logic [bsa_pkg::INDEX_W-1:0]  res_idx_ff, res_idx_in;
   bsa_pkg::status_type          res_status_ff, res_status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bsa_pkg::INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   bsa_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [WORD_BITS-1:0]  ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [WORD_BITS-1:0]  ram_rd_data;

   logic                  issue;
   logic [CW-1:0]         base;
   logic [WORD_BITS-1:0]  beyond;
   logic [WORD_BITS-1:0]  free_bits;
   logic [WORD_BITS-1:0]  low_bit;
   logic [BW-1:0]         low_enc;
   logic [CW-1:0]         grant_slot;
   logic [PW-1:0]         div_prod;
   logic [CW-1:0]         rem_full;
   logic [CW-1:0]         req_idx_ext;
   logic                  req_out_of_range;
   logic                  out_free;

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NWORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign issue = (state_ff == bsa_pkg::ST_SCAN) && (word_ff < WCW'(NWORDS));
   assign ram_rd_addr = issue ? word_ff[AW-1:0] : quot_ff;

   assign base = CW'(chk_ff) * CW'(WORD_BITS);

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         beyond[b] = (base + CW'(b)) >= count_ff;
      end
   end

   assign free_bits = ~(ram_rd_data | beyond);
   assign low_bit   = free_bits & (~free_bits + WORD_BITS'(1));

   always_comb begin
      low_enc = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_bit[b]) begin
            low_enc = low_enc | BW'(b);
         end
      end
   end

   assign grant_slot = base + CW'(low_enc);
   assign div_prod   = PW'(idx_ff) * PW'(DIV_MULT);
   assign rem_full   = CW'(idx_ff) - CW'(quot_ff) * CW'(WORD_BITS);

   assign req_idx_ext      = CW'(req_tdata[bsa_pkg::INDEX_W-1:0]);
   assign req_out_of_range = (req_idx_ext >= count_ff) || (req_idx_ext >= CW'(SLOTS));
   assign out_free         = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      chk_in        = chk_ff;
      pend_in       = 1'b0;
      idx_in        = idx_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ff;
      ram_wr_data   = '0;

      case (state_ff)
         bsa_pkg::ST_CLEAR: begin
            ram_wr_en = 1'b1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NWORDS - 1)) begin
               state_in = bsa_pkg::ST_IDLE;
            end
         end
         bsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               idx_in = req_tdata[bsa_pkg::INDEX_W-1:0];
               if (req_tuser[0] == bsa_pkg::OP_ALLOC) begin
                  word_in  = '0;
                  state_in = bsa_pkg::ST_SCAN;
               end else if (req_out_of_range) begin
                  res_idx_in    = req_tdata[bsa_pkg::INDEX_W-1:0];
                  res_status_in = bsa_pkg::STATUS_RANGE;
                  state_in      = bsa_pkg::ST_DONE;
               end else begin
                  state_in = bsa_pkg::ST_DIV;
               end
            end
         end
         bsa_pkg::ST_SCAN: begin
            if (issue) begin
               word_in = word_ff + WCW'(1);
               chk_in  = word_ff[AW-1:0];
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (free_bits != '0) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = chk_ff;
                  ram_wr_data   = ram_rd_data | low_bit;
                  res_idx_in    = grant_slot[bsa_pkg::INDEX_W-1:0];
                  res_status_in = bsa_pkg::STATUS_OK;
                  state_in      = bsa_pkg::ST_DONE;
               end else if (!issue) begin
                  res_idx_in    = '0;
                  res_status_in = bsa_pkg::STATUS_FULL;
                  state_in      = bsa_pkg::ST_DONE;
               end
            end
         end
         bsa_pkg::ST_DIV: begin
            quot_in  = AW'(div_prod >> bsa_pkg::DIV_SHIFT);
            state_in = bsa_pkg::ST_RD;
         end
         bsa_pkg::ST_RD: begin
            bit_in   = rem_full[BW-1:0];
            state_in = bsa_pkg::ST_FREE;
         end
         bsa_pkg::ST_FREE: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = quot_ff;
            ram_wr_data   = ram_rd_data & ~(WORD_BITS'(1) << bit_ff);
            res_idx_in    = idx_ff;
            res_status_in = bsa_pkg::STATUS_OK;
            state_in      = bsa_pkg::ST_DONE;
         end
         bsa_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_status_in = res_status_ff;
               state_in      = bsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsa_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      if (csr_wr_en) begin
         count_in = (CW'(csr_wr_data) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(csr_wr_data);
         clr_in   = '0;
         state_in = bsa_pkg::ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::ST_CLEAR;
         count_ff     <= CW'(COUNT_INIT);
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      chk_ff        <= chk_in;
      idx_ff        <= idx_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == bsa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_idx_ff);
   assign rsp_tuser  = rsp_status_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsa_pkg::ST_CLEAR) |-> !req_tready)
      else $error("request accepted during clearing pass");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !csr_wr_en) |=> (state_ff != bsa_pkg::ST_IDLE))
      else $error("accepted request did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bsa_pkg::ST_DONE))
      else $error("response raised outside completion");

   a_full_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == bsa_pkg::STATUS_FULL)) |-> (rsp_idx_ff == '0))
      else $error("full response carries a slot index");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int HALF_PERIOD = 6;
   localparam int NWORDS      = bsa_pkg::SLOTS_DEFAULT / bsa_pkg::WORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int PRINT_CAP   = 40;

   typedef struct {
      logic [bsa_pkg::INDEX_W-1:0] slot;
      bsa_pkg::status_type         status;
   } grant_type;

   class slot_bitmap_mirror;
      bit [bsa_pkg::WORD_BITS_DEFAULT-1:0] used_words [NWORDS];
      int unsigned slot_count;
      grant_type pending_grants[$];

      function void set_count(logic [bsa_pkg::COUNT_W-1:0] value);
         slot_count = (value > bsa_pkg::SLOTS_DEFAULT) ? bsa_pkg::SLOTS_DEFAULT : value;
         for (int w = 0; w < NWORDS; w++)
            for (int b = 0; b < bsa_pkg::WORD_BITS_DEFAULT; b++)
               used_words[w][b] = (w * bsa_pkg::WORD_BITS_DEFAULT + b >= slot_count);
      endfunction

      function void note_request(bsa_pkg::op_type op, logic [bsa_pkg::INDEX_W-1:0] idx);
         grant_type g;
         bit found;
         found = 0;
         if (op == bsa_pkg::OP_ALLOC) begin
            g.slot = '0;
            g.status = bsa_pkg::STATUS_FULL;
            for (int w = 0; w < NWORDS && !found; w++)
               for (int b = 0; b < bsa_pkg::WORD_BITS_DEFAULT && !found; b++)
                  if (!used_words[w][b]) begin
                     used_words[w][b] = 1'b1;
                     g.slot = bsa_pkg::INDEX_W'(w * bsa_pkg::WORD_BITS_DEFAULT + b);
                     g.status = bsa_pkg::STATUS_OK;
                     found = 1;
                  end
         end else begin
            g.slot = idx;
            if (idx >= slot_count) begin
               g.status = bsa_pkg::STATUS_RANGE;
            end else begin
               used_words[idx / bsa_pkg::WORD_BITS_DEFAULT]
                         [idx % bsa_pkg::WORD_BITS_DEFAULT] = 1'b0;
               g.status = bsa_pkg::STATUS_OK;
            end
         end
         pending_grants.push_back(g);
      endfunction

      function int taken_slot();
         int taken[$];
         for (int s = 0; s < slot_count; s++)
            if (used_words[s / bsa_pkg::WORD_BITS_DEFAULT][s % bsa_pkg::WORD_BITS_DEFAULT])
               taken.push_back(s);
         if (taken.size() == 0)
            return $urandom_range(bsa_pkg::SLOTS_DEFAULT - 1);
         return taken[$urandom_range(taken.size() - 1)];
      endfunction

      function string check_result(logic [bsa_pkg::INDEX_W-1:0] slot,
                                   logic [bsa_pkg::STATUS_W-1:0] status);
         grant_type exp_grant;
         string msg;
         if (pending_grants.size() == 0)
            return $sformatf("unexpected result slot=%0d status=%0d", slot, status);
         exp_grant = pending_grants.pop_front();
         msg = "";
         if (slot !== exp_grant.slot)
            msg = {msg, $sformatf(" slot got %0d exp %0d", slot, exp_grant.slot)};
         if (status !== exp_grant.status)
            msg = {msg, $sformatf(" status got %0d exp %0d", status, exp_grant.status)};
         return msg;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   slot_bitmap_mirror board;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  calm = 0;
   bit  hold_request = 0;

   bitmap_slot_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_slot_allocator_unit test failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH at %0t:%s", $realtime, what);
   endtask

   // hold off for a long stretch on request, otherwise stall in short random bursts unless calm
   initial begin
      int hold_left;
      int stall_left;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         msg = board.check_result(rsp_tdata[bsa_pkg::INDEX_W-1:0], rsp_tuser);
         if (msg != "")
            report_mismatch(msg);
      end
   end

   task automatic send_request(bsa_pkg::op_type op, logic [bsa_pkg::INDEX_W-1:0] idx);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, idx};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, idx);
   endtask

   task automatic idle_for(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_grants.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_slot_count(logic [bsa_pkg::COUNT_W-1:0] value);
      drain_results();
      repeat (NWORDS + 8) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_count(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [bsa_pkg::INDEX_W-1:0] pick_free_target();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return bsa_pkg::INDEX_W'(board.taken_slot());
      if (r < 85 && board.slot_count > 0)
         return bsa_pkg::INDEX_W'($urandom_range(board.slot_count - 1));
      return bsa_pkg::INDEX_W'($urandom);
   endfunction

   task automatic run_phase(logic [bsa_pkg::COUNT_W-1:0] count_value, int items,
                            int alloc_pct, bit pause_midway, bit long_hold);
      bsa_pkg::op_type op;
      logic [bsa_pkg::INDEX_W-1:0] idx;
      write_slot_count(count_value);
      for (int i = 0; i < items; i++) begin
         if (long_hold && i == 8)
            hold_request = 1;
         if (!calm && $urandom_range(3) == 0)
            idle_for($urandom_range(1, 3));
         op  = ($urandom_range(99) < alloc_pct) ? bsa_pkg::OP_ALLOC : bsa_pkg::OP_FREE;
         idx = (op == bsa_pkg::OP_FREE) ? pick_free_target() : bsa_pkg::INDEX_W'($urandom);
         send_request(op, idx);
         if (pause_midway && i == items / 2)
            drain_results();
      end
   endtask

   initial begin
      board = new();
      board.set_count(bsa_pkg::COUNT_RESET);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (NWORDS + 8) @(posedge clock);

      send_request(bsa_pkg::OP_ALLOC, 10'd0);
      send_request(bsa_pkg::OP_FREE, 10'd1023);
      send_request(bsa_pkg::OP_FREE, 10'd0);

      write_slot_count(11'd3);
      repeat (4) send_request(bsa_pkg::OP_ALLOC, 10'h3FF);
      send_request(bsa_pkg::OP_FREE, 10'd1);
      send_request(bsa_pkg::OP_ALLOC, 10'd0);
      send_request(bsa_pkg::OP_FREE, 10'd3);
      send_request(bsa_pkg::OP_FREE, 10'd1023);
      send_request(bsa_pkg::OP_FREE, 10'd0);
      send_request(bsa_pkg::OP_FREE, 10'd0);
      send_request(bsa_pkg::OP_ALLOC, 10'd0);

      write_slot_count(11'd0);
      send_request(bsa_pkg::OP_ALLOC, 10'd0);
      send_request(bsa_pkg::OP_FREE, 10'd0);

      write_slot_count(11'd2047);
      send_request(bsa_pkg::OP_FREE, 10'd1023);
      send_request(bsa_pkg::OP_ALLOC, 10'h155);
      send_request(bsa_pkg::OP_FREE, 10'h2AA);
      send_request(bsa_pkg::OP_FREE, 10'h155);

      write_slot_count(11'd1);
      send_request(bsa_pkg::OP_ALLOC, 10'd0);
      send_request(bsa_pkg::OP_ALLOC, 10'd0);
      send_request(bsa_pkg::OP_FREE, 10'd1);

      run_phase(11'd40, 120, 60, 0, 0);
      run_phase(11'd1, 60, 50, 0, 0);
      run_phase(11'd1024, 200, 70, 1, 1);
      run_phase(11'd2047, 80, 60, 0, 0);
      run_phase(11'd33, 100, 60, 0, 0);
      run_phase(11'd0, 20, 50, 0, 0);
      calm = 1;
      run_phase(11'd96, 100, 60, 0, 0);

      drain_results();
      repeat (NWORDS + 8) @(posedge clock);
      if (mismatch_count == 0 && board.pending_grants.size() == 0)
         $display("bitmap_slot_allocator_unit test passed");
      else
         $display("bitmap_slot_allocator_unit test failed");
      $finish;
   end

endmodule
